// File: hw/rtl/epsilon_ball_novelty_interval_set_unit_macros.svh
// Assertion macros for the interval set unit.
`ifndef EPSILON_BALL_NOVELTY_INTERVAL_SET_UNIT_MACROS_SVH
`define EPSILON_BALL_NOVELTY_INTERVAL_SET_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define EBN_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Next-cycle implication.
`define EBN_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/ebnis_pkg.sv
// ----------------------------------------------------------------------------
// ebnis_pkg
// Types and constants shared by the interval set unit.
// ----------------------------------------------------------------------------
`default_nettype none
package ebnis_pkg;
    localparam int MAX_INTERVALS = 64;
    localparam int IDX_W = $clog2(MAX_INTERVALS);
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

    localparam logic [1:0] OP_OBSERVE = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DOMAIN  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] CFG_DLOW   = 2'd0;
    localparam logic [1:0] CFG_DHIGH  = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] point;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        novel_flag;
        logic [6:0]  stored_intervals;
        logic [31:0] covered_length;
        logic        whole_domain_covered;
        logic [63:0] observation_total;
        logic [63:0] novel_total;
        logic [63:0] generation_total;
    } t_out;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_ival;

    // Memory port bundle from the sequencer to the table.
    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_ival            wdata;
    } t_mem_req;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_RUN, S_SHIFT_UP, S_SHIFT_DN, S_WRITE, S_DONE
    } t_state;
endpackage
`default_nettype wire

// File: hw/rtl/ebnis_table.sv
// ----------------------------------------------------------------------------
// ebnis_table
// Interval memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module ebnis_table (
    input  wire logic              i_clk,
    input  wire ebnis_pkg::t_mem_req i_req,
    output ebnis_pkg::t_ival       o_rdata
);
    ebnis_pkg::t_ival r_mem [ebnis_pkg::MAX_INTERVALS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/epsilon_ball_novelty_interval_set_unit.sv
// ----------------------------------------------------------------------------
// epsilon_ball_novelty_interval_set_unit
// Sorted set of disjoint closed intervals with epsilon-ball insert and merge.
// ----------------------------------------------------------------------------
//  channel | direction | handshake       | payload
//  in      | input     | i_valid/o_ready | ebnis_pkg::t_in
//  out     | output    | o_valid/i_ready | ebnis_pkg::t_out
//  cfg     | input     | i_cfg_we        | i_cfg_index, i_cfg_data
//
// One item at a time; n is the number of stored intervals. A query scans the
// n entries through the registered read port, then decides and loads the
// result. Clear, a point outside the domain and the unused opcode go straight
// to the result. An observe scans and decides, then ends when the ball sits
// inside one interval or the table is full, writes the merged interval when
// nothing moves, or first shifts m entries one slot per cycle (m <= n).
// Reset is synchronous and active low; the table needs no clearing pass.
// The result sits in an output register; ready drops until it is taken and
// returns the cycle after the output transfer.
// ----------------------------------------------------------------------------
`default_nettype none
module epsilon_ball_novelty_interval_set_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire ebnis_pkg::t_in   i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output ebnis_pkg::t_out       o_data,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [31:0]      i_cfg_data
);
    localparam int IW = ebnis_pkg::IDX_W;
    localparam int CW = ebnis_pkg::CNT_W;
    localparam logic [CW-1:0] MAXC = CW'(ebnis_pkg::MAX_INTERVALS);

    // configuration
    logic signed [31:0] r_dlow, r_dhigh;
    logic [30:0]        r_rad;

    // architectural state
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_sum, n_sum;
    logic [63:0]   r_obs, n_obs, r_nov, n_nov, r_gen, n_gen;
    ebnis_pkg::t_ival r_first0, n_first0; // copy of entry 0 for whole-domain test

    // per-item working registers
    ebnis_pkg::t_state r_state, n_state;
    logic [1:0]         r_op, n_op;
    logic signed [31:0] r_x, n_x, r_lo, n_lo, r_hi, n_hi;
    logic [CW-1:0]      r_idx, n_idx;     // scan pointer (address issued)
    logic               r_rv, n_rv;       // read data valid this cycle
    logic [CW-1:0]      r_ridx, n_ridx;   // index of the data being returned
    logic [CW-1:0]      r_first, n_first, r_last, n_last;
    logic               r_ffound, n_ffound;
    logic               r_cov, n_cov;
    logic [31:0]        r_rem, n_rem;
    logic [CW-1:0]      r_ptr, n_ptr;     // shift pointer
    logic               r_ovalid, n_ovalid;
    ebnis_pkg::t_out    r_out, n_out;

    ebnis_pkg::t_mem_req s_req;
    ebnis_pkg::t_ival    s_rd;

    ebnis_table u_table (.i_clk(i_clk), .i_req(s_req), .o_rdata(s_rd));

    // clamped ball from the incoming point
    logic signed [32:0] s_blo, s_bhi;
    logic signed [31:0] s_clo, s_chi;
    logic               s_indom;
    always_comb begin
        s_blo = 33'(i_data.point) - $signed({2'b00, r_rad});
        s_bhi = 33'(i_data.point) + $signed({2'b00, r_rad});
        s_clo = (s_blo <= 33'(r_dlow)) ? r_dlow : s_blo[31:0];
        s_chi = (s_bhi >= 33'(r_dhigh)) ? r_dhigh : s_bhi[31:0];
        s_indom = !(i_data.point < r_dlow || i_data.point > r_dhigh);
    end

    function automatic logic [63:0] sat(input logic [63:0] v);
        sat = (v == '1) ? v : v + 64'd1;
    endfunction

    assign o_ready = (r_state == ebnis_pkg::S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // run length once the scan is done; merged span equal to the removed
    // span means the ball already lies inside the single overlapped interval
    logic [CW-1:0]      s_k;
    logic               s_inside;
    always_comb begin
        s_k = r_last - r_first;
        s_inside = (s_k == CW'(1)) && (32'(r_hi - r_lo) == r_rem);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ebnis_pkg::S_IDLE: begin
                if (i_valid && o_ready) begin
                    if ((i_data.opcode == ebnis_pkg::OP_OBSERVE ||
                         i_data.opcode == ebnis_pkg::OP_QUERY) && s_indom)
                        n_state = ebnis_pkg::S_SCAN;
                    else
                        n_state = ebnis_pkg::S_DONE;
                end
            end
            ebnis_pkg::S_SCAN: begin
                if (!r_rv && r_idx >= r_count) n_state = ebnis_pkg::S_RUN;
                else if (r_rv && r_ridx + 1'b1 >= r_count) n_state = ebnis_pkg::S_RUN;
            end
            ebnis_pkg::S_RUN: begin
                if (r_op != ebnis_pkg::OP_OBSERVE) n_state = ebnis_pkg::S_DONE;
                else if (s_k == '0) begin
                    if (r_count >= MAXC) n_state = ebnis_pkg::S_DONE;
                    else if (r_first == r_count) n_state = ebnis_pkg::S_WRITE;
                    else n_state = ebnis_pkg::S_SHIFT_UP;
                end else if (s_inside) n_state = ebnis_pkg::S_DONE;
                else if (r_last == r_count) n_state = ebnis_pkg::S_WRITE;
                else n_state = ebnis_pkg::S_SHIFT_DN;
            end
            ebnis_pkg::S_SHIFT_UP: begin
                if (r_rv && r_ptr == r_first + 1'b1) n_state = ebnis_pkg::S_WRITE;
            end
            ebnis_pkg::S_SHIFT_DN: begin
                if (r_rv && r_ptr + 1'b1 >= r_count) n_state = ebnis_pkg::S_WRITE;
            end
            ebnis_pkg::S_WRITE: n_state = ebnis_pkg::S_DONE;
            ebnis_pkg::S_DONE:  n_state = ebnis_pkg::S_IDLE;
            default: n_state = ebnis_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_op = r_op; n_x = r_x; n_lo = r_lo; n_hi = r_hi;
        n_idx = r_idx; n_rv = 1'b0; n_ridx = r_ridx;
        n_first = r_first; n_last = r_last; n_ffound = r_ffound;
        n_cov = r_cov; n_rem = r_rem; n_ptr = r_ptr;
        n_count = r_count; n_sum = r_sum; n_obs = r_obs; n_nov = r_nov; n_gen = r_gen;
        n_first0 = r_first0;
        n_ovalid = r_ovalid; n_out = r_out;
        s_req = '0;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        case (r_state)
            ebnis_pkg::S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_op = i_data.opcode; n_x = i_data.point;
                    n_lo = s_clo; n_hi = s_chi;
                    n_idx = '0; n_first = '0; n_last = '0; n_ffound = 1'b0;
                    n_cov = 1'b0; n_rem = '0;
                    n_out.status = ebnis_pkg::ST_OK;
                    n_out.novel_flag = 1'b0;
                    if (i_data.opcode == ebnis_pkg::OP_OBSERVE ||
                        i_data.opcode == ebnis_pkg::OP_QUERY) begin
                        if (!s_indom) n_out.status = ebnis_pkg::ST_DOMAIN;
                    end else if (i_data.opcode == ebnis_pkg::OP_CLEAR) begin
                        n_count = '0; n_sum = '0; n_obs = '0; n_nov = '0;
                        n_gen = sat(r_gen);
                    end
                end
            end
            ebnis_pkg::S_SCAN: begin
                // issue reads in order; process the returned entry
                if (r_idx < r_count) begin
                    s_req.re = 1'b1;
                    s_req.raddr = r_idx[IW-1:0];
                    n_idx = r_idx + 1'b1;
                    n_rv = 1'b1;
                    n_ridx = r_idx;
                end
                if (r_rv) begin
                    if (s_rd.lo <= r_x && r_x <= s_rd.hi) n_cov = 1'b1;
                    if (!r_ffound) begin
                        if (s_rd.hi < r_lo) begin
                            n_first = r_ridx + 1'b1; n_last = r_ridx + 1'b1;
                        end else begin
                            n_ffound = 1'b1;
                        end
                    end
                    if ((r_ffound || !(s_rd.hi < r_lo)) && s_rd.lo <= r_hi &&
                        r_last == r_ridx) begin
                        n_last = r_ridx + 1'b1;
                        n_rem = r_rem + 32'(s_rd.hi - s_rd.lo);
                        if (r_last == r_first && s_rd.lo < r_lo) n_lo = s_rd.lo;
                        if (s_rd.hi > r_hi) n_hi = s_rd.hi;
                    end
                end
            end
            ebnis_pkg::S_RUN: begin
                // r_cov: the point was covered by a stored interval
                n_out.novel_flag = !r_cov;
                if (r_op == ebnis_pkg::OP_OBSERVE) begin
                    if (s_k == '0 && r_count >= MAXC) n_out.status = ebnis_pkg::ST_FULL;
                    else begin
                        n_obs = sat(r_obs); n_gen = sat(r_gen);
                        if (!r_cov) n_nov = sat(r_nov);
                    end
                    if (s_k == '0) begin
                        n_ptr = r_count;   // shift entries [first, count) up by one
                        n_rv = 1'b0;
                    end else begin
                        n_ptr = r_last;    // move entries [last, count) down to first+1
                    end
                end
                // ball inside one interval: exit without writes (next state)
            end
            ebnis_pkg::S_SHIFT_UP: begin
                // read ptr-1, write it at ptr
                if (!r_rv) begin
                    s_req.re = 1'b1; s_req.raddr = IW'(r_ptr - 1'b1);
                    n_rv = 1'b1;
                end else begin
                    s_req.we = 1'b1; s_req.waddr = r_ptr[IW-1:0]; s_req.wdata = s_rd;
                    n_ptr = r_ptr - 1'b1;
                    if (r_ptr != r_first + 1'b1) begin
                        s_req.re = 1'b1; s_req.raddr = IW'(r_ptr - 2'd2);
                        n_rv = 1'b1;
                    end
                end
            end
            ebnis_pkg::S_SHIFT_DN: begin
                if (!r_rv) begin
                    s_req.re = 1'b1; s_req.raddr = r_ptr[IW-1:0];
                    n_rv = 1'b1;
                end else begin
                    s_req.we = 1'b1;
                    s_req.waddr = IW'(r_ptr - (r_last - r_first) + 1'b1);
                    s_req.wdata = s_rd;
                    n_ptr = r_ptr + 1'b1;
                    if (r_ptr + 1'b1 < r_count) begin
                        s_req.re = 1'b1; s_req.raddr = IW'(r_ptr + 1'b1);
                        n_rv = 1'b1;
                    end
                end
            end
            ebnis_pkg::S_WRITE: begin
                s_req.we = 1'b1; s_req.waddr = r_first[IW-1:0];
                s_req.wdata.lo = r_lo; s_req.wdata.hi = r_hi;
                n_count = r_count - s_k + 1'b1;
                n_sum = r_sum - r_rem + 32'(r_hi - r_lo);
                if (r_first == '0) begin
                    n_first0.lo = r_lo; n_first0.hi = r_hi;
                end
            end
            ebnis_pkg::S_DONE: begin
                n_ovalid = 1'b1;
                n_out.stored_intervals = 7'(r_count);
                n_out.covered_length = r_sum;
                n_out.whole_domain_covered = (r_count == CW'(1)) &&
                    (r_first0.lo == r_dlow) && (r_first0.hi == r_dhigh);
                n_out.observation_total = r_obs;
                n_out.novel_total = r_nov;
                n_out.generation_total = r_gen;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ebnis_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_rv <= 1'b0;
            r_count <= '0; r_sum <= '0; r_obs <= '0; r_nov <= '0; r_gen <= '0;
            r_dlow <= 32'sd0; r_dhigh <= 32'sd65536; r_rad <= 31'd6554;
        end else begin
            r_state <= n_state; r_ovalid <= n_ovalid; r_rv <= n_rv;
            r_count <= n_count; r_sum <= n_sum;
            r_obs <= n_obs; r_nov <= n_nov; r_gen <= n_gen;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ebnis_pkg::CFG_DLOW:   r_dlow  <= i_cfg_data;
                    ebnis_pkg::CFG_DHIGH:  r_dhigh <= i_cfg_data;
                    ebnis_pkg::CFG_RADIUS: r_rad   <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_x <= n_x; r_lo <= n_lo; r_hi <= n_hi;
        r_idx <= n_idx; r_ridx <= n_ridx; r_first <= n_first; r_last <= n_last;
        r_ffound <= n_ffound; r_cov <= n_cov; r_rem <= n_rem; r_ptr <= n_ptr;
        r_out <= n_out; r_first0 <= n_first0;
    end
endmodule
`default_nettype wire

// File: hw/rtl/ebnis_checker.sv
// ----------------------------------------------------------------------------
// ebnis_checker
// Port-level checks on the interval set unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "epsilon_ball_novelty_interval_set_unit_macros.svh"
module ebnis_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_ready,
    input wire logic            o_valid,
    input wire logic            i_ready,
    input wire ebnis_pkg::t_out o_data
);
    `EBN_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
    `EBN_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, o_valid, !o_ready)
    `EBN_ASSERT_IMP(a_count_range, i_clk, i_rst_n, o_valid,
        o_data.stored_intervals <= 7'(ebnis_pkg::MAX_INTERVALS))
    `EBN_ASSERT_IMP(a_nov_le_obs, i_clk, i_rst_n, o_valid,
        o_data.novel_total <= o_data.observation_total)
endmodule
bind epsilon_ball_novelty_interval_set_unit ebnis_checker u_chk (.*);
`default_nettype wire
